// ===== design/rcts_pkg.sv =====
// shared types and constants for the revolution-count test sequencer
package rcts_pkg;

  // request codes
  localparam logic [2:0] REQ_MODE  = 3'd0;
  localparam logic [2:0] REQ_START = 3'd1;
  localparam logic [2:0] REQ_STOP  = 3'd2;
  localparam logic [2:0] REQ_KNOB  = 3'd3;
  localparam logic [2:0] REQ_POS   = 3'd4;

  // register indexes
  localparam logic [2:0] REG_DEBOUNCE = 3'd0;
  localparam logic [2:0] REG_CLICK    = 3'd1;
  localparam logic [2:0] REG_KNOB_THR = 3'd2;
  localparam logic [2:0] REG_SPD_MIN  = 3'd3;
  localparam logic [2:0] REG_SPD_MAX  = 3'd4;
  localparam logic [2:0] REG_PPR      = 3'd5;
  localparam logic [2:0] REG_DUTY     = 3'd6;

  // register reset values
  localparam logic [15:0] DEBOUNCE_RST = 16'd50;
  localparam logic [15:0] CLICK_RST    = 16'd500;
  localparam logic [15:0] KNOB_THR_RST = 16'd1;
  localparam logic [9:0]  SPD_MIN_RST  = 10'd10;
  localparam logic [9:0]  SPD_MAX_RST  = 10'd100;
  localparam logic [15:0] PPR_RST      = 16'd1000;
  localparam logic [9:0]  DUTY_RST     = 10'd500;

  // setting reset values
  localparam logic [9:0] SPEED_RST  = 10'd60;
  localparam logic       DIR_RST    = 1'b1;
  localparam logic [9:0] TARGET_RST = 10'd30;
  localparam logic [1:0] CURSOR_RST = 2'd1;

  // edit limits
  localparam logic signed [11:0] TARGET_MIN = 12'sd10;
  localparam logic signed [11:0] TARGET_MAX = 12'sd999;
  localparam logic signed [3:0]  ITEM_FIRST = 4'sd1;
  localparam logic signed [3:0]  ITEM_LAST  = 4'sd3;

  // drive level: floor(duty * 499 / 1000) as (duty * LEVEL_MULT) >> LEVEL_SHIFT,
  // exact for duty up to DUTY_FULL
  localparam logic [9:0]  DUTY_FULL   = 10'd1000;
  localparam int          LEVEL_SHIFT = 20;
  localparam logic [19:0] LEVEL_MULT  = 20'd523240;

  // one result word
  typedef struct packed {
    logic [1:0] mode_now;
    logic [1:0] motor_cmd;
    logic [8:0] drive_level;
    logic [9:0] revs_done;
    logic [9:0] speed_setting;
    logic       dir_setting;
    logic [9:0] target_setting;
    logic [1:0] cursor_item;
    logic [2:0] edit_flags;
    logic       save_strobe;
  } result_t;

endpackage

// ===== design/rev_count_test_sequencer.sv =====
// Each result word is registered in the output register, or in the skid stage if that is full.
// Throughput: one word per cycle; a two-entry output register and skid stage keep
// taking words while the oldest result is stalled, and in_stall rises only when both are full.
// All work for a word is one pass of shallow logic from the ports into the result register.
// Reset (rst_n low, synchronous) restores register defaults, idle mode, speed 60,
// clockwise, target 30, cursor on item 1, nothing edited, motor braked, no results held.
module rev_count_test_sequencer
  import rcts_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_req_type,
  input  logic [15:0]        in_press_ms,
  input  logic [15:0]        in_knob_count,
  input  logic signed [31:0] in_motor_position,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_mode_now,
  output logic [1:0]         out_motor_cmd,
  output logic [8:0]         out_drive_level,
  output logic [9:0]         out_revs_done,
  output logic [9:0]         out_speed_setting,
  output logic               out_dir_setting,
  output logic [9:0]         out_target_setting,
  output logic [1:0]         out_cursor_item,
  output logic [2:0]         out_edit_flags,
  output logic               out_save_strobe,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_MENU   = 2'd1,
    MODE_RUN    = 2'd2,
    MODE_RESULT = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    MOT_BRAKE = 2'd0,
    MOT_FWD   = 2'd1,
    MOT_REV   = 2'd2
  } motor_t;

  // configuration registers
  logic [15:0] debounce_r, click_r, knob_thr_r, ppr_r;
  logic [9:0]  spd_min_r, spd_max_r, duty_r;
  logic [2:0]  cfg_idx;
  logic        cfg_wr;

  // block state
  mode_t       mode_r, mode_nxt;
  motor_t      motor_r, motor_nxt;
  logic [9:0]  speed_r, speed_nxt;
  logic        dir_r, dir_nxt;
  logic [9:0]  target_r, target_nxt;
  logic [1:0]  cursor_r, cursor_nxt;
  logic [2:0]  edit_r, edit_nxt;
  logic [15:0] knob_last_r, knob_last_nxt;
  logic [31:0] base_r, base_nxt;
  logic [9:0]  revs_r, revs_nxt;
  logic        save;

  // knob and position datapath
  logic signed [16:0] knob_delta;
  logic [16:0]        knob_mag;
  logic               knob_step_ok;
  logic signed [11:0] step12;
  logic signed [3:0]  step4;
  logic signed [11:0] spd_sum, spd_clamp;
  logic signed [11:0] tgt_sum, tgt_clamp;
  logic signed [3:0]  cur_sum, cur_clamp;
  logic [31:0]        pos_diff, pos_mag;
  logic [9:0]         revs_inc;

  // drive level
  logic [9:0]  duty_c;
  logic [29:0] level_prod;
  logic [8:0]  level;

  // output register and skid stage
  result_t res_nxt, out_res_r, skid_res_r;
  logic    out_vld_r, skid_vld_r;
  logic    in_accept, out_take;

  // handshake
  assign in_stall  = skid_vld_r;
  assign in_accept = in_valid && !skid_vld_r;
  assign out_valid = out_vld_r;
  assign out_take  = out_vld_r && !out_stall;

  // configuration write and read
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      click_r    <= CLICK_RST;
      knob_thr_r <= KNOB_THR_RST;
      spd_min_r  <= SPD_MIN_RST;
      spd_max_r  <= SPD_MAX_RST;
      ppr_r      <= PPR_RST;
      duty_r     <= DUTY_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DEBOUNCE: debounce_r <= pwdata[15:0];
        REG_CLICK:    click_r    <= pwdata[15:0];
        REG_KNOB_THR: knob_thr_r <= pwdata[15:0];
        REG_SPD_MIN:  spd_min_r  <= pwdata[9:0];
        REG_SPD_MAX:  spd_max_r  <= pwdata[9:0];
        REG_PPR:      ppr_r      <= pwdata[15:0];
        REG_DUTY:     duty_r     <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_DEBOUNCE: prdata = {16'd0, debounce_r};
      REG_CLICK:    prdata = {16'd0, click_r};
      REG_KNOB_THR: prdata = {16'd0, knob_thr_r};
      REG_SPD_MIN:  prdata = {22'd0, spd_min_r};
      REG_SPD_MAX:  prdata = {22'd0, spd_max_r};
      REG_PPR:      prdata = {16'd0, ppr_r};
      REG_DUTY:     prdata = {22'd0, duty_r};
      default:      prdata = 32'd0;
    endcase
  end

  // knob step with clamping per item
  assign knob_delta   = $signed({1'b0, in_knob_count}) - $signed({1'b0, knob_last_r});
  assign knob_mag     = knob_delta[16] ? 17'(-knob_delta) : 17'(knob_delta);
  assign knob_step_ok = knob_mag > {1'b0, knob_thr_r};
  assign step12       = knob_delta[16] ? -12'sd1 : 12'sd1;
  assign step4        = knob_delta[16] ? -4'sd1 : 4'sd1;

  always_comb begin
    spd_sum   = $signed({2'b00, speed_r}) + step12;
    spd_clamp = spd_sum;
    if (spd_clamp > $signed({2'b00, spd_max_r})) spd_clamp = $signed({2'b00, spd_max_r});
    if (spd_clamp < $signed({2'b00, spd_min_r})) spd_clamp = $signed({2'b00, spd_min_r});
    tgt_sum   = $signed({2'b00, target_r}) + step12;
    tgt_clamp = tgt_sum;
    if (tgt_clamp > TARGET_MAX) tgt_clamp = TARGET_MAX;
    if (tgt_clamp < TARGET_MIN) tgt_clamp = TARGET_MIN;
    cur_sum   = $signed({2'b00, cursor_r}) + step4;
    cur_clamp = cur_sum;
    if (cur_clamp > ITEM_LAST) cur_clamp = ITEM_LAST;
    if (cur_clamp < ITEM_FIRST) cur_clamp = ITEM_FIRST;
  end

  // position change magnitude with 32-bit wrap
  assign pos_diff = in_motor_position - base_r;
  assign pos_mag  = pos_diff[31] ? (32'd0 - pos_diff) : pos_diff;
  assign revs_inc = revs_r + 10'd1;

  // next state for one word
  always_comb begin
    mode_nxt      = mode_r;
    motor_nxt     = motor_r;
    speed_nxt     = speed_r;
    dir_nxt       = dir_r;
    target_nxt    = target_r;
    cursor_nxt    = cursor_r;
    edit_nxt      = edit_r;
    knob_last_nxt = knob_last_r;
    base_nxt      = base_r;
    revs_nxt      = revs_r;
    save          = 1'b0;
    case (in_req_type)
      REQ_MODE: begin
        if (in_press_ms > debounce_r && in_press_ms <= click_r) begin
          if (mode_r == MODE_IDLE) begin
            mode_nxt = MODE_MENU;
          end else if (mode_r == MODE_MENU && cursor_r != 2'd0) begin
            edit_nxt = edit_r ^ (3'd1 << (cursor_r - 2'd1));
          end
        end else if (in_press_ms > click_r && mode_r == MODE_MENU) begin
          mode_nxt = MODE_IDLE;
          save     = 1'b1;
        end
      end
      REQ_START: begin
        if (mode_r == MODE_IDLE) begin
          mode_nxt  = MODE_RUN;
          motor_nxt = dir_r ? MOT_FWD : MOT_REV;
        end else if (mode_r == MODE_MENU) begin
          mode_nxt = MODE_IDLE;
          save     = 1'b1;
        end
      end
      REQ_STOP: begin
        if (mode_r == MODE_RUN) begin
          mode_nxt  = MODE_RESULT;
          motor_nxt = MOT_BRAKE;
        end else if (mode_r == MODE_RESULT) begin
          revs_nxt = 10'd0;
          mode_nxt = MODE_IDLE;
        end
      end
      REQ_KNOB: begin
        if (mode_r != MODE_MENU) begin
          knob_last_nxt = in_knob_count;
        end else if (knob_step_ok) begin
          knob_last_nxt = in_knob_count;
          if (edit_r[0]) begin
            speed_nxt = spd_clamp[9:0];
          end else if (edit_r[1]) begin
            dir_nxt = !knob_delta[16];
          end else if (edit_r[2]) begin
            target_nxt = tgt_clamp[9:0];
          end else begin
            cursor_nxt = cur_clamp[1:0];
          end
        end
      end
      REQ_POS: begin
        if (mode_r == MODE_RUN) begin
          if (pos_mag > {16'd0, ppr_r}) begin
            revs_nxt = revs_inc;
            base_nxt = in_motor_position;
          end
          if (revs_nxt >= target_r) begin
            revs_nxt  = target_r;
            mode_nxt  = MODE_RESULT;
            motor_nxt = MOT_BRAKE;
          end
        end
      end
      default: ;
    endcase
  end

  // drive level from the clamped duty
  assign duty_c     = (duty_r > DUTY_FULL) ? DUTY_FULL : duty_r;
  assign level_prod = duty_c * LEVEL_MULT;
  assign level      = level_prod[LEVEL_SHIFT+8:LEVEL_SHIFT];

  // result word
  always_comb begin
    res_nxt.mode_now       = mode_nxt;
    res_nxt.motor_cmd      = motor_nxt;
    res_nxt.drive_level    = (motor_nxt != MOT_BRAKE) ? level : 9'd0;
    res_nxt.revs_done      = revs_nxt;
    res_nxt.speed_setting  = speed_nxt;
    res_nxt.dir_setting    = dir_nxt;
    res_nxt.target_setting = target_nxt;
    res_nxt.cursor_item    = cursor_nxt;
    res_nxt.edit_flags     = edit_nxt;
    res_nxt.save_strobe    = save;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      motor_r     <= MOT_BRAKE;
      speed_r     <= SPEED_RST;
      dir_r       <= DIR_RST;
      target_r    <= TARGET_RST;
      cursor_r    <= CURSOR_RST;
      edit_r      <= 3'd0;
      knob_last_r <= 16'd0;
      base_r      <= 32'd0;
      revs_r      <= 10'd0;
    end else if (in_accept) begin
      mode_r      <= mode_nxt;
      motor_r     <= motor_nxt;
      speed_r     <= speed_nxt;
      dir_r       <= dir_nxt;
      target_r    <= target_nxt;
      cursor_r    <= cursor_nxt;
      edit_r      <= edit_nxt;
      knob_last_r <= knob_last_nxt;
      base_r      <= base_nxt;
      revs_r      <= revs_nxt;
    end
  end

  // output and skid valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_take || !out_vld_r) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= in_accept;
      end
    end else if (in_accept) begin
      skid_vld_r <= 1'b1;
    end
  end

  // output and skid payload
  always_ff @(posedge clk) begin
    if (out_take || !out_vld_r) begin
      if (skid_vld_r) begin
        out_res_r <= skid_res_r;
      end else if (in_accept) begin
        out_res_r <= res_nxt;
      end
    end else if (in_accept) begin
      skid_res_r <= res_nxt;
    end
  end

  // result ports
  assign out_mode_now       = out_res_r.mode_now;
  assign out_motor_cmd      = out_res_r.motor_cmd;
  assign out_drive_level    = out_res_r.drive_level;
  assign out_revs_done      = out_res_r.revs_done;
  assign out_speed_setting  = out_res_r.speed_setting;
  assign out_dir_setting    = out_res_r.dir_setting;
  assign out_target_setting = out_res_r.target_setting;
  assign out_cursor_item    = out_res_r.cursor_item;
  assign out_edit_flags     = out_res_r.edit_flags;
  assign out_save_strobe    = out_res_r.save_strobe;

endmodule
